FILE: rtl/core/kclru_pkg.sv
// Shared types and fixed field widths for the keyed LRU cache core.
// Used by keyed_cache_lru_batch_prune_core; no dependencies.
package kclru_pkg;

  localparam int KEY_W    = 32;
  localparam int HANDLE_W = 32;
  localparam int EVICT_W  = 4;

  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_LOOKUP = 7'b0000100,
    ST_PRUNE  = 7'b0001000,
    ST_INSERT = 7'b0010000,
    ST_RESULT = 7'b0100000,
    ST_SPARE  = 7'b1000000
  } state_t;

endpackage

FILE: rtl/core/keyed_cache_lru_batch_prune_core.sv
// Top level of the fully associative LRU cache keyed by (decl_id, program_id).
// Depends on kclru_pkg and kclru_ram.
//
// After reset the core runs a clearing pass over the entry memory and accepts
// no transfer until it ends. Each lookup then reads every entry through the
// single read port of the entry RAM, one per cycle; a miss into a table that
// is not full writes its new entry in an insert step after the scan. A miss on
// a full table adds one oldest-stamp pass over the entries for each removed
// entry, up to PRUNE_COUNT passes. One lookup is in flight at a time; the
// result register lets the next input transfer be taken while a result still
// waits.
module keyed_cache_lru_batch_prune_core #(
  parameter int CAPACITY    = 64,
  parameter int PRUNE_COUNT = 8,
  parameter int STAMP_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // decl_id[31:0], program_id[63:32], new_handle[95:64]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // handle[31:0], evicted_count[35:32], zero[39:36]
  output logic [0:0]  out_tuser   // hit[0]
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = $clog2(PRUNE_COUNT + 1);
  localparam int SW = STAMP_WIDTH;
  localparam int KW = kclru_pkg::KEY_W;
  localparam int HW = kclru_pkg::HANDLE_W;
  localparam int WW = 1 + 2 * KW + HW + SW;

  localparam int H_LO = SW;
  localparam int P_LO = SW + HW;
  localparam int D_LO = SW + HW + KW;
  localparam int V_POS = SW + HW + 2 * KW;

  localparam logic [IW:0]   CAP_I  = (IW + 1)'(CAPACITY);
  localparam logic [IW-1:0] LAST_I = IW'(CAPACITY - 1);
  localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
  localparam logic [EW-1:0] PRUNE_E = EW'(PRUNE_COUNT);

  kclru_pkg::state_t state_r, state_nxt;

  logic [IW:0]    issue_r, issue_nxt;
  logic           cmp_vld_r;
  logic [IW-1:0]  cmp_idx_r;
  logic [KW-1:0]  key_decl_r, key_decl_nxt;
  logic [KW-1:0]  key_prog_r, key_prog_nxt;
  logic [HW-1:0]  key_hnd_r, key_hnd_nxt;
  logic           found_r, found_nxt;
  logic [IW-1:0]  found_idx_r, found_idx_nxt;
  logic [HW-1:0]  hit_hnd_r, hit_hnd_nxt;
  logic           free_r, free_nxt;
  logic [IW-1:0]  free_idx_r, free_idx_nxt;
  logic           best_r, best_nxt;
  logic [IW-1:0]  best_idx_r, best_idx_nxt;
  logic [SW-1:0]  best_stamp_r, best_stamp_nxt;
  logic [IW-1:0]  slot_r, slot_nxt;
  logic [EW-1:0]  ev_r, ev_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic [SW-1:0]  ctr_r, ctr_nxt;
  logic           res_hit_r, res_hit_nxt;
  logic [HW-1:0]  res_hnd_r, res_hnd_nxt;
  logic [kclru_pkg::EVICT_W-1:0] res_ev_r, res_ev_nxt;
  logic           out_vld_r, out_vld_nxt;
  logic           out_hit_r;
  logic [HW-1:0]  out_hnd_r;
  logic [kclru_pkg::EVICT_W-1:0] out_ev_r;

  logic           issuing;
  logic           scan_done;
  logic           out_load;
  logic           we;
  logic [IW-1:0]  waddr;
  logic [WW-1:0]  wdata;
  logic [WW-1:0]  rdata;
  logic           rd_vld;
  logic [KW-1:0]  rd_decl;
  logic [KW-1:0]  rd_prog;
  logic [HW-1:0]  rd_hnd;
  logic [SW-1:0]  rd_stamp;
  logic [EW-1:0]  ev_inc;

  assign rd_vld   = rdata[V_POS];
  assign rd_decl  = rdata[D_LO +: KW];
  assign rd_prog  = rdata[P_LO +: KW];
  assign rd_hnd   = rdata[H_LO +: HW];
  assign rd_stamp = rdata[0 +: SW];

  assign issuing   = ((state_r == kclru_pkg::ST_LOOKUP) || (state_r == kclru_pkg::ST_PRUNE))
                     && (issue_r != CAP_I);
  assign scan_done = cmp_vld_r && (cmp_idx_r == LAST_I);
  assign out_load  = (state_r == kclru_pkg::ST_RESULT) && (!out_vld_r || out_tready);
  assign ev_inc    = ev_r + 1'b1;

  kclru_ram #(
    .WIDTH(WW),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(issue_r[IW-1:0]),
    .rdata(rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    issue_nxt      = issue_r;
    key_decl_nxt   = key_decl_r;
    key_prog_nxt   = key_prog_r;
    key_hnd_nxt    = key_hnd_r;
    found_nxt      = found_r;
    found_idx_nxt  = found_idx_r;
    hit_hnd_nxt    = hit_hnd_r;
    free_nxt       = free_r;
    free_idx_nxt   = free_idx_r;
    best_nxt       = best_r;
    best_idx_nxt   = best_idx_r;
    best_stamp_nxt = best_stamp_r;
    slot_nxt       = slot_r;
    ev_nxt         = ev_r;
    count_nxt      = count_r;
    ctr_nxt        = ctr_r;
    res_hit_nxt    = res_hit_r;
    res_hnd_nxt    = res_hnd_r;
    res_ev_nxt     = res_ev_r;
    out_vld_nxt    = out_vld_r;
    we             = 1'b0;
    waddr          = issue_r[IW-1:0];
    wdata          = '0;

    if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
    if (out_load) begin
      out_vld_nxt = 1'b1;
    end

    if (issuing) begin
      issue_nxt = issue_r + 1'b1;
    end

    if (cmp_vld_r && (state_r == kclru_pkg::ST_LOOKUP)) begin
      if (rd_vld && (rd_decl == key_decl_r) && (rd_prog == key_prog_r)) begin
        found_nxt     = 1'b1;
        found_idx_nxt = cmp_idx_r;
        hit_hnd_nxt   = rd_hnd;
      end
      if (!rd_vld && !free_r) begin
        free_nxt     = 1'b1;
        free_idx_nxt = cmp_idx_r;
      end
    end
    if (cmp_vld_r && (state_r == kclru_pkg::ST_PRUNE)) begin
      if (rd_vld && (!best_r || (rd_stamp < best_stamp_r))) begin
        best_nxt       = 1'b1;
        best_idx_nxt   = cmp_idx_r;
        best_stamp_nxt = rd_stamp;
      end
    end

    case (state_r)
      kclru_pkg::ST_CLEAR: begin
        we        = 1'b1;
        waddr     = issue_r[IW-1:0];
        issue_nxt = issue_r + 1'b1;
        if (issue_r[IW-1:0] == LAST_I) begin
          issue_nxt = '0;
          state_nxt = kclru_pkg::ST_IDLE;
        end
      end
      kclru_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          key_decl_nxt = in_tdata[31:0];
          key_prog_nxt = in_tdata[63:32];
          key_hnd_nxt  = in_tdata[95:64];
          issue_nxt    = '0;
          found_nxt    = 1'b0;
          free_nxt     = 1'b0;
          ev_nxt       = '0;
          state_nxt    = kclru_pkg::ST_LOOKUP;
        end
      end
      kclru_pkg::ST_LOOKUP: begin
        if (scan_done) begin
          if (found_nxt) begin
            ctr_nxt     = ctr_r + 1'b1;
            we          = 1'b1;
            waddr       = found_idx_nxt;
            wdata       = {1'b1, key_decl_r, key_prog_r, hit_hnd_nxt, ctr_nxt};
            res_hit_nxt = 1'b1;
            res_hnd_nxt = hit_hnd_nxt;
            res_ev_nxt  = '0;
            state_nxt   = kclru_pkg::ST_RESULT;
          end else if (count_r == CAP_C) begin
            issue_nxt = '0;
            best_nxt  = 1'b0;
            state_nxt = kclru_pkg::ST_PRUNE;
          end else begin
            slot_nxt  = free_idx_nxt;
            state_nxt = kclru_pkg::ST_INSERT;
          end
        end
      end
      kclru_pkg::ST_PRUNE: begin
        if (scan_done) begin
          we        = 1'b1;
          waddr     = best_idx_nxt;
          wdata     = '0;
          ev_nxt    = ev_inc;
          count_nxt = count_r - 1'b1;
          if ((ev_r == '0) || (best_idx_nxt < slot_r)) begin
            slot_nxt = best_idx_nxt;
          end
          if ((ev_inc < PRUNE_E) && (count_r > CW'(1))) begin
            issue_nxt = '0;
            best_nxt  = 1'b0;
          end else begin
            state_nxt = kclru_pkg::ST_INSERT;
          end
        end
      end
      kclru_pkg::ST_INSERT: begin
        ctr_nxt     = ctr_r + SW'(2);
        we          = 1'b1;
        waddr       = slot_r;
        wdata       = {1'b1, key_decl_r, key_prog_r, key_hnd_r, ctr_nxt};
        count_nxt   = count_r + 1'b1;
        res_hit_nxt = 1'b0;
        res_hnd_nxt = key_hnd_r;
        res_ev_nxt  = kclru_pkg::EVICT_W'(ev_r);
        state_nxt   = kclru_pkg::ST_RESULT;
      end
      kclru_pkg::ST_RESULT: begin
        if (out_load) begin
          state_nxt = kclru_pkg::ST_IDLE;
        end
      end
      default: begin
        issue_nxt = '0;
        state_nxt = kclru_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= kclru_pkg::ST_CLEAR;
      issue_r   <= '0;
      cmp_vld_r <= 1'b0;
      found_r   <= 1'b0;
      free_r    <= 1'b0;
      best_r    <= 1'b0;
      ev_r      <= '0;
      count_r   <= '0;
      ctr_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      issue_r   <= issue_nxt;
      cmp_vld_r <= issuing;
      found_r   <= found_nxt;
      free_r    <= free_nxt;
      best_r    <= best_nxt;
      ev_r      <= ev_nxt;
      count_r   <= count_nxt;
      ctr_r     <= ctr_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r    <= issue_r[IW-1:0];
    key_decl_r   <= key_decl_nxt;
    key_prog_r   <= key_prog_nxt;
    key_hnd_r    <= key_hnd_nxt;
    found_idx_r  <= found_idx_nxt;
    hit_hnd_r    <= hit_hnd_nxt;
    free_idx_r   <= free_idx_nxt;
    best_idx_r   <= best_idx_nxt;
    best_stamp_r <= best_stamp_nxt;
    slot_r       <= slot_nxt;
    res_hit_r    <= res_hit_nxt;
    res_hnd_r    <= res_hnd_nxt;
    res_ev_r     <= res_ev_nxt;
    if (out_load) begin
      out_hit_r <= res_hit_r;
      out_hnd_r <= res_hnd_r;
      out_ev_r  <= res_ev_r;
    end
  end

  assign in_tready  = (state_r == kclru_pkg::ST_IDLE);
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {4'b0000, out_ev_r, out_hnd_r};
  assign out_tuser  = out_hit_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_C)
    else $error("entry count exceeds capacity");

  a_evict_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ev_r <= PRUNE_E)
    else $error("eviction count exceeds prune limit");

  a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == kclru_pkg::ST_INSERT) |-> (count_r < CAP_C))
    else $error("insert into a full table");

  a_accept_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == kclru_pkg::ST_LOOKUP) && (issue_r == '0))
    else $error("accepted transfer did not start a lookup");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_vld_r && (state_r == kclru_pkg::ST_IDLE))
    else $error("result was not presented");

endmodule

FILE: rtl/core/kclru_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module kclru_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: verif/kclru_checker.sv
// Checker for keyed_cache_lru_batch_prune_core: watches both stream channels,
// predicts each lookup result and compares it with the result transfers.
// Depends on kclru_pkg for the field widths.
module kclru_checker #(
  parameter int CAPACITY    = 64,
  parameter int PRUNE_COUNT = 8,
  parameter int STAMP_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [95:0] in_tdata,   // decl_id[31:0], program_id[63:32], new_handle[95:64]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,  // handle[31:0], evicted_count[35:32], zero[39:36]
  input  logic [0:0]  out_tuser,  // hit[0]
  output int          mismatch_count,
  output int          pending_lookups
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                           hit;
    logic [kclru_pkg::HANDLE_W-1:0] handle;
    logic [kclru_pkg::EVICT_W-1:0]  evicted;
  } lookup_result_t;

  bit                             slot_valid  [CAPACITY];
  bit [kclru_pkg::KEY_W-1:0]      slot_decl   [CAPACITY];
  bit [kclru_pkg::KEY_W-1:0]      slot_prog   [CAPACITY];
  bit [kclru_pkg::HANDLE_W-1:0]   slot_handle [CAPACITY];
  bit [STAMP_WIDTH-1:0]           slot_stamp  [CAPACITY];
  bit [STAMP_WIDTH-1:0]           use_ctr;
  int                             live_entries;
  int                             err_total;
  lookup_result_t                 expected_lookups[$];
  lookup_result_t                 want;

  function automatic lookup_result_t cache_predict(
      input logic [kclru_pkg::KEY_W-1:0]    decl,
      input logic [kclru_pkg::KEY_W-1:0]    prog,
      input logic [kclru_pkg::HANDLE_W-1:0] hnew);
    lookup_result_t res;
    int             slot;
    int             oldest;
    int             removed;
    bit             found;
    res     = '0;
    removed = 0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (slot_valid[i] && slot_decl[i] == decl && slot_prog[i] == prog) begin
        use_ctr       = use_ctr + 1'b1;
        slot_stamp[i] = use_ctr;
        res.hit       = 1'b1;
        res.handle    = slot_handle[i];
        return res;
      end
    end
    if (live_entries >= CAPACITY) begin
      found = 1'b1;
      while (removed < PRUNE_COUNT && found) begin
        found  = 1'b0;
        oldest = 0;
        for (int i = 0; i < CAPACITY; i++) begin
          if (slot_valid[i] && (!found || slot_stamp[i] < slot_stamp[oldest])) begin
            oldest = i;
            found  = 1'b1;
          end
        end
        if (found) begin
          slot_valid[oldest] = 1'b0;
          live_entries--;
          removed++;
        end
      end
    end
    slot = 0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        slot = i;
      end
    end
    // A miss advances the counter once at creation and once at use.
    use_ctr           = use_ctr + 2'd2;
    slot_valid[slot]  = 1'b1;
    slot_decl[slot]   = decl;
    slot_prog[slot]   = prog;
    slot_handle[slot] = hnew;
    slot_stamp[slot]  = use_ctr;
    if (live_entries < CAPACITY) begin
      live_entries++;
    end
    res.hit     = 1'b0;
    res.handle  = hnew;
    res.evicted = removed[kclru_pkg::EVICT_W-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CAPACITY; i++) begin
        slot_valid[i] = 1'b0;
      end
      use_ctr      = '0;
      live_entries = 0;
      expected_lookups.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_lookups.size() == 0) begin
          $error("result transfer with no lookup pending: tdata %h, tuser %h",
                 out_tdata, out_tuser);
          err_total++;
        end else begin
          want = expected_lookups.pop_front();
          if (out_tuser[0] !== want.hit) begin
            $error("hit: expected %0d, actual %0d", want.hit, out_tuser[0]);
            err_total++;
          end
          if (out_tdata[31:0] !== want.handle) begin
            $error("handle: expected %h, actual %h", want.handle, out_tdata[31:0]);
            err_total++;
          end
          if (out_tdata[35:32] !== want.evicted) begin
            $error("evicted_count: expected %0d, actual %0d", want.evicted,
                   out_tdata[35:32]);
            err_total++;
          end
          if (out_tdata[39:36] !== 4'h0) begin
            $error("pad: expected %h, actual %h", 4'h0, out_tdata[39:36]);
            err_total++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        expected_lookups = {expected_lookups,
                            cache_predict(in_tdata[31:0], in_tdata[63:32],
                                          in_tdata[95:64])};
      end
    end
    mismatch_count  <= err_total;
    pending_lookups <= expected_lookups.size();
  end

endmodule

FILE: verif/tb_keyed_cache_lru_batch_prune_core.sv
// Testbench top for keyed_cache_lru_batch_prune_core: drives directed and random
// lookups with random idling on both channels and gives the verdict.
// Depends on kclru_pkg, the core and kclru_checker.
module tb_keyed_cache_lru_batch_prune_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY     = 64;
  localparam int PRUNE_COUNT  = 8;
  localparam int STAMP_WIDTH  = 32;
  localparam int POOL_SIZE    = 80;
  localparam int HOT_SIZE     = 16;
  localparam int RANDOM_ITEMS = 900;
  localparam int PRESSURE_AT  = 120;
  localparam int HOLD_CYCLES  = 1200;
  localparam int DRAIN_CYCLES = (CAPACITY + 1) * (PRUNE_COUNT + 1) + 64;
  localparam int IDLE_LIMIT   = 20000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [95:0] in_tdata;   // decl_id[31:0], program_id[63:32], new_handle[95:64]
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // handle[31:0], evicted_count[35:32], zero[39:36]
  logic [0:0]  out_tuser;  // hit[0]
  int          mismatches;
  int          pending_lookups;

  logic [kclru_pkg::KEY_W-1:0] pool_decl [POOL_SIZE];
  logic [kclru_pkg::KEY_W-1:0] pool_prog [POOL_SIZE];

  keyed_cache_lru_batch_prune_core #(
    .CAPACITY   (CAPACITY),
    .PRUNE_COUNT(PRUNE_COUNT),
    .STAMP_WIDTH(STAMP_WIDTH)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  kclru_checker #(
    .CAPACITY   (CAPACITY),
    .PRUNE_COUNT(PRUNE_COUNT),
    .STAMP_WIDTH(STAMP_WIDTH)
  ) i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .mismatch_count (mismatches),
    .pending_lookups(pending_lookups)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int pick_gap(input bit steady);
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) begin
      return 0;
    end else if (r < 88) begin
      return $urandom_range(1, 4);
    end else if (r < 97) begin
      return $urandom_range(5, 40);
    end
    return $urandom_range(60, 250);
  endfunction

  function automatic logic [kclru_pkg::HANDLE_W-1:0] pick_handle();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) begin
      return '0;
    end else if (r == 1) begin
      return '1;
    end
    return $urandom;
  endfunction

  task automatic push_lookup(input logic [kclru_pkg::KEY_W-1:0]    decl,
                             input logic [kclru_pkg::KEY_W-1:0]    prog,
                             input logic [kclru_pkg::HANDLE_W-1:0] hnew,
                             input int gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {hnew, prog, decl};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  initial begin : lookup_source
    int  pick;
    int  idx;
    bit  steady;
    logic [kclru_pkg::KEY_W-1:0] decl;
    logic [kclru_pkg::KEY_W-1:0] prog;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    steady    = 1'b0;
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_decl[i] = $urandom;
      pool_prog[i] = $urandom;
      if (i % 4 == 1) begin
        pool_decl[i] = pool_decl[i-1];
      end else if (i % 4 == 3) begin
        pool_prog[i] = pool_prog[i-1];
      end
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // A failed creation stores a null handle that later hits; keys that share
    // one half with a stored key must still miss.
    push_lookup(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, pick_gap(1'b0));
    push_lookup(32'h0000_0000, 32'h0000_0000, 32'h1234_5678, pick_gap(1'b0));
    push_lookup(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, pick_gap(1'b0));
    push_lookup(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, pick_gap(1'b0));
    push_lookup(32'h0000_0000, 32'hFFFF_FFFF, 32'hA5A5_A5A5, pick_gap(1'b0));
    push_lookup(32'hFFFF_FFFF, 32'h0000_0000, 32'h5A5A_5A5A, pick_gap(1'b0));
    push_lookup(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, pick_gap(1'b0));
    push_lookup(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, pick_gap(1'b0));
    push_lookup(32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000, pick_gap(1'b0));
    push_lookup(32'h0000_0001, 32'h0000_0000, 32'h0000_0001, pick_gap(1'b0));
    push_lookup(32'h0000_0000, 32'h0000_0001, 32'h8000_0000, pick_gap(1'b0));
    push_lookup(32'h8000_0000, 32'h0000_0000, 32'h7FFF_FFFF, pick_gap(1'b0));
    push_lookup(32'h0000_0000, 32'h8000_0000, 32'hFFFF_FFFE, pick_gap(1'b0));
    push_lookup(32'h0000_0001, 32'h0000_0000, 32'h0000_0000, pick_gap(1'b0));
    push_lookup(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0002, pick_gap(1'b0));
    push_lookup(32'h0000_0000, 32'h0000_0000, 32'h0000_0003, pick_gap(1'b0));

    // A hot subset keeps its stamps fresh while the rest of the pool overflows
    // the table, so pruning must remove the cold entries.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 60 == 0) begin
        steady = ($urandom_range(0, 3) == 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        idx  = $urandom_range(0, HOT_SIZE - 1);
        decl = pool_decl[idx];
        prog = pool_prog[idx];
      end else if (pick < 88) begin
        idx  = $urandom_range(0, POOL_SIZE - 1);
        decl = pool_decl[idx];
        prog = pool_prog[idx];
      end else begin
        decl = $urandom;
        prog = $urandom;
      end
      push_lookup(decl, prog, pick_handle(), pick_gap(steady));
    end
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (pending_lookups != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_lookups == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : result_sink
    int taken;
    int stall;
    bit steady;
    taken      = 0;
    steady     = 1'b0;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (taken % 40 == 0) begin
        steady = ($urandom_range(0, 3) == 0);
      end
      if (taken == PRESSURE_AT) begin
        stall = HOLD_CYCLES;
      end else begin
        stall = pick_gap(steady);
      end
      if (taken != PRESSURE_AT && (steady || $urandom_range(0, 2) == 0)) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        @(posedge clk);
        while (!out_tvalid) @(posedge clk);
        repeat (stall) @(posedge clk);
        out_tready <= 1'b1;
      end
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      taken++;
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("tb: failure");
    $finish;
  end

endmodule
